FILE: rtl/usd_pkg.sv
// Shared types, constants and lead-byte decode for the UTF-8 stream decoder.
package usd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 31;
  localparam int unsigned CountW = 3;

  localparam logic [ByteW-1:0] AsciiMax   = 8'h7f;
  localparam logic [ByteW-1:0] PayloadMsk = 8'h3f;
  localparam logic [ByteW-1:0] ContMin    = 8'h80;
  localparam logic [ByteW-1:0] ContMax    = 8'hbf;
  localparam logic [ByteW-1:0] LeadMin    = 8'hc2;
  localparam logic [ByteW-1:0] LeadMax    = 8'hfd;

  typedef struct packed {
    logic [CpW-1:0]    code_point;
    logic [CountW-1:0] byte_count;
    logic              error;
  } res_t;

  // Sequence length set by a lead byte; zero for a byte that cannot lead.
  function automatic logic [CountW-1:0] lead_length(input logic [ByteW-1:0] b);
    logic [CountW-1:0] len;
    len = 3'd0;
    if (b <= AsciiMax) begin
      len = 3'd1;
    end else if (b >= LeadMin && b <= LeadMax) begin
      case (b[7:2])
        6'b110000, 6'b110001, 6'b110010, 6'b110011,
        6'b110100, 6'b110101, 6'b110110, 6'b110111: len = 3'd2;
        6'b111000, 6'b111001, 6'b111010, 6'b111011: len = 3'd3;
        6'b111100, 6'b111101:                       len = 3'd4;
        6'b111110:                                  len = 3'd5;
        6'b111111:                                  len = 3'd6;
        default:                                    len = 3'd0;
      endcase
    end
    return len;
  endfunction

  // Payload bits kept from a lead byte of a multi-byte sequence.
  function automatic logic [ByteW-1:0] lead_payload(input logic [ByteW-1:0] b,
                                                    input logic [CountW-1:0] len);
    logic [ByteW-1:0] p;
    case (len)
      3'd2:    p = b & 8'h1f;
      3'd3:    p = b & 8'h0f;
      3'd4:    p = b & 8'h07;
      3'd5:    p = b & 8'h03;
      3'd6:    p = b & 8'h01;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/utf8_stream_decoder_unit.sv
// Top level of the byte-serial UTF-8 decoder (sequences of up to six bytes).
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+------------------------------------
//   bytes   | data_valid | data_stall | data_byte
//   chars   | char_valid | char_stall | code_point, byte_count, error
//
// One byte per cycle sustained while the result buffer has room; each byte is decoded from the input register.
// A result passes from the input register through the decode stage into the result buffer before it is valid.
// data_stall comes from registered status only, never from char_stall directly.
// Synchronous reset returns the decoder to idle and empties both buffers.
module utf8_stream_decoder_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        data_valid,
  output logic                        data_stall,
  input  logic [usd_pkg::ByteW-1:0]   data_byte,
  output logic                        char_valid,
  input  logic                        char_stall,
  output logic [usd_pkg::CpW-1:0]     code_point,
  output logic [usd_pkg::CountW-1:0]  byte_count,
  output logic                        error
);

  logic                      held_valid;
  logic [usd_pkg::ByteW-1:0] held_byte;
  logic                      room;
  logic                      advance;
  logic                      emit;
  usd_pkg::res_t             res;

  assign advance = held_valid && room;

  usd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .take       (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  usd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .byte_in (held_byte),
    .emit    (emit),
    .res     (res)
  );

  usd_result_buf u_result_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (advance && emit),
    .push_res   (res),
    .room       (room),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .code_point (code_point),
    .byte_count (byte_count),
    .error      (error)
  );

endmodule

FILE: rtl/usd_in_reg.sv
// Input register: holds one byte until the decode stage takes it.
module usd_in_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        data_valid,
  output logic                        data_stall,
  input  logic [usd_pkg::ByteW-1:0]   data_byte,
  input  logic                        take,
  output logic                        held_valid,
  output logic [usd_pkg::ByteW-1:0]   held_byte
);

  logic load;

  assign data_stall = held_valid && !take;
  assign load       = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= load || (held_valid && !take);
    end
    if (load) begin
      held_byte <= data_byte;
    end
  end

endmodule

FILE: rtl/usd_decode.sv
// Decode stage: sequence state and per-byte decode of one held byte.
module usd_decode (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [usd_pkg::ByteW-1:0]   byte_in,
  output logic                        emit,
  output usd_pkg::res_t               res
);

  logic [usd_pkg::CpW-1:0]    accumulator, accumulator_next;
  logic [usd_pkg::CountW-1:0] bytes_remaining, bytes_remaining_next;
  logic [usd_pkg::CountW-1:0] sequence_length, sequence_length_next;
  logic [usd_pkg::CountW-1:0] len;
  logic [usd_pkg::CpW-1:0]    shifted;
  logic                       is_cont;

  assign len     = usd_pkg::lead_length(byte_in);
  assign is_cont = byte_in >= usd_pkg::ContMin && byte_in <= usd_pkg::ContMax;
  assign shifted = {accumulator[usd_pkg::CpW-7:0], byte_in[5:0] & usd_pkg::PayloadMsk[5:0]};

  always_comb begin
    emit                 = 1'b0;
    res                  = '0;
    accumulator_next     = '0;
    bytes_remaining_next = '0;
    sequence_length_next = '0;
    if (bytes_remaining == 3'd0) begin
      if (len == 3'd0) begin
        emit      = 1'b1;
        res.error = 1'b1;
      end else if (len == 3'd1) begin
        emit           = 1'b1;
        res.code_point = {{(usd_pkg::CpW-7){1'b0}}, byte_in[6:0] & usd_pkg::AsciiMax[6:0]};
        res.byte_count = 3'd1;
      end else begin
        accumulator_next     = {{(usd_pkg::CpW-usd_pkg::ByteW){1'b0}},
                                usd_pkg::lead_payload(byte_in, len)};
        bytes_remaining_next = len - 3'd1;
        sequence_length_next = len;
      end
    end else if (!is_cont) begin
      emit      = 1'b1;
      res.error = 1'b1;
    end else if (bytes_remaining == 3'd1) begin
      emit           = 1'b1;
      res.code_point = shifted;
      res.byte_count = sequence_length;
    end else begin
      accumulator_next     = shifted;
      bytes_remaining_next = bytes_remaining - 3'd1;
      sequence_length_next = sequence_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      bytes_remaining <= '0;
      sequence_length <= '0;
    end else if (advance) begin
      accumulator     <= accumulator_next;
      bytes_remaining <= bytes_remaining_next;
      sequence_length <= sequence_length_next;
    end
  end

endmodule

FILE: rtl/usd_result_buf.sv
// Two-entry result buffer: decouples output stall from the decode stage.
module usd_result_buf (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  usd_pkg::res_t               push_res,
  output logic                        room,
  output logic                        char_valid,
  input  logic                        char_stall,
  output logic [usd_pkg::CpW-1:0]     code_point,
  output logic [usd_pkg::CountW-1:0]  byte_count,
  output logic                        error
);

  usd_pkg::res_t head, tail;
  logic [1:0]    count;
  logic          pop;

  assign room       = count != 2'd2;
  assign char_valid = count != 2'd0;
  assign pop        = char_valid && !char_stall;
  assign code_point = head.code_point;
  assign byte_count = head.byte_count;
  assign error      = head.error;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push && pop) begin
      if (count == 2'd1) begin
        head <= push_res;
      end else begin
        head <= tail;
        tail <= push_res;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_res;
      end else begin
        tail <= push_res;
      end
    end else if (pop) begin
      head <= tail;
    end
  end

endmodule

FILE: sim/utf8_stream_decoder_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the byte-serial UTF-8 stream decoder unit.
module utf8_stream_decoder_unit_test;

  logic                       clk        = 1'b0;
  logic                       rst        = 1'b1;
  logic                       data_valid = 1'b0;
  logic                       data_stall;
  logic [usd_pkg::ByteW-1:0]  data_byte  = '0;
  logic                       char_valid;
  logic                       char_stall = 1'b0;
  logic [usd_pkg::CpW-1:0]    code_point;
  logic [usd_pkg::CountW-1:0] byte_count;
  logic                       error;

  usd_pkg::res_t              pending_chars[$];
  usd_pkg::res_t              oldest_char;
  logic [usd_pkg::CpW-1:0]    char_acc   = '0;
  logic [usd_pkg::CountW-1:0] cont_left  = '0;
  logic [usd_pkg::CountW-1:0] char_len   = '0;
  int unsigned                idle_pct   = 0;
  int unsigned                mismatches = 0;
  int unsigned                bytes_sent = 0;

  utf8_stream_decoder_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .code_point (code_point),
    .byte_count (byte_count),
    .error      (error)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("utf8_stream_decoder_unit regression: fail");
    $finish;
  end

  function automatic int unsigned seq_length(input logic [usd_pkg::ByteW-1:0] b);
    if (b <= 8'h7f) return 1;
    if (b >= 8'hc2 && b <= 8'hdf) return 2;
    if (b >= 8'he0 && b <= 8'hef) return 3;
    if (b >= 8'hf0 && b <= 8'hf7) return 4;
    if (b >= 8'hf8 && b <= 8'hfb) return 5;
    if (b >= 8'hfc && b <= 8'hfd) return 6;
    return 0;
  endfunction

  function automatic void expect_char(input logic [usd_pkg::CpW-1:0] cp,
                                      input logic [usd_pkg::CountW-1:0] cnt,
                                      input logic err);
    usd_pkg::res_t r;
    r.code_point = cp;
    r.byte_count = cnt;
    r.error      = err;
    pending_chars.push_back(r);
  endfunction

  function automatic void decode_byte(input logic [usd_pkg::ByteW-1:0] b);
    int unsigned len;
    if (cont_left == 0) begin
      len = seq_length(b);
      if (len == 0) begin
        expect_char('0, '0, 1'b1);
      end else if (len == 1) begin
        expect_char(usd_pkg::CpW'(b[6:0]), usd_pkg::CountW'(1), 1'b0);
      end else begin
        char_acc  = usd_pkg::CpW'(b & ((8'd1 << (7 - len)) - 8'd1));
        cont_left = usd_pkg::CountW'(len - 1);
        char_len  = usd_pkg::CountW'(len);
      end
    end else if (b < usd_pkg::ContMin || b > usd_pkg::ContMax) begin
      expect_char('0, '0, 1'b1);
      char_acc  = '0;
      cont_left = '0;
      char_len  = '0;
    end else begin
      char_acc  = {char_acc[usd_pkg::CpW-7:0], b[5:0]};
      cont_left = cont_left - 1'b1;
      if (cont_left == 0) begin
        expect_char(char_acc, char_len, 1'b0);
        char_acc = '0;
        char_len = '0;
      end
    end
  endfunction

  function automatic logic [usd_pkg::ByteW-1:0] random_lead(input int unsigned len);
    case (len)
      1:       return usd_pkg::ByteW'($urandom_range(8'h00, 8'h7f));
      2:       return usd_pkg::ByteW'($urandom_range(8'hc2, 8'hdf));
      3:       return usd_pkg::ByteW'($urandom_range(8'he0, 8'hef));
      4:       return usd_pkg::ByteW'($urandom_range(8'hf0, 8'hf7));
      5:       return usd_pkg::ByteW'($urandom_range(8'hf8, 8'hfb));
      default: return usd_pkg::ByteW'($urandom_range(8'hfc, 8'hfd));
    endcase
  endfunction

  function automatic logic [usd_pkg::ByteW-1:0] random_cont();
    return usd_pkg::ContMin | usd_pkg::ByteW'($urandom_range(0, 63));
  endfunction

  function automatic logic [usd_pkg::ByteW-1:0] random_breaker();
    if ($urandom_range(1) == 1) return usd_pkg::ByteW'($urandom_range(8'h00, 8'h7f));
    return usd_pkg::ByteW'($urandom_range(8'hc0, 8'hff));
  endfunction

  always @(posedge clk) begin
    char_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && char_valid && !char_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected transfer: code_point %h byte_count %0d error %b",
               code_point, byte_count, error);
        mismatches++;
      end else begin
        oldest_char = pending_chars.pop_front();
        if (code_point !== oldest_char.code_point) begin
          $error("code_point: expected %h, actual %h", oldest_char.code_point, code_point);
          mismatches++;
        end
        if (byte_count !== oldest_char.byte_count) begin
          $error("byte_count: expected %0d, actual %0d", oldest_char.byte_count, byte_count);
          mismatches++;
        end
        if (error !== oldest_char.error) begin
          $error("error: expected %b, actual %b", oldest_char.error, error);
          mismatches++;
        end
      end
    end
  end

  task automatic send_byte(input logic [usd_pkg::ByteW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    do @(posedge clk); while (data_stall);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic test_ascii();
    send_byte(8'h00);
    send_byte(8'h7f);
  endtask

  task automatic test_sequences();
    send_byte(8'hc2);
    send_byte(8'h80);
    send_byte(8'hef);
    repeat (2) send_byte(8'hbf);
    send_byte(8'hfd);
    repeat (5) send_byte(8'hbf);
  endtask

  task automatic test_bad_leads();
    send_byte(8'h80);
    send_byte(8'hbf);
    send_byte(8'hc0);
    send_byte(8'hc1);
    send_byte(8'hfe);
    send_byte(8'hff);
  endtask

  task automatic test_broken_sequences();
    send_byte(8'he2);
    send_byte(8'h41);
    send_byte(8'hc3);
    send_byte(8'hc3);
  endtask

  task automatic test_random_stream(input int unsigned count);
    int unsigned stop;
    int unsigned pick;
    int unsigned len;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = $urandom_range(1, 6);
        send_byte(random_lead(len));
        repeat (len - 1) send_byte(random_cont());
      end else if (pick < 85) begin
        len = $urandom_range(2, 6);
        send_byte(random_lead(len));
        repeat ($urandom_range(0, len - 2)) send_byte(random_cont());
        send_byte(random_breaker());
      end else begin
        send_byte(usd_pkg::ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    idle_pct = 34;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_ascii();
    test_sequences();
    test_bad_leads();
    test_broken_sequences();
    test_random_stream(300);
    idle_pct = 0;
    test_random_stream(150);
    idle_pct = 34;
    test_random_stream(350);
    data_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("utf8_stream_decoder_unit regression: pass");
    end else begin
      $display("utf8_stream_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule
